// File: hdl/efc_pkg.sv
// shared types, constants and sine table function for the fly camera update block
// used by efc_ctrl, efc_dpath and euler_fly_camera_update
package efc_pkg;

    localparam int SINE_DEPTH_DEF = 1024;

    // angles are degrees in Q.16
    localparam logic [24:0] FULL_TURN    = 25'd23592960;
    localparam logic [24:0] HALF_TURN    = 25'd11796480;
    localparam logic [24:0] QUARTER_TURN = 25'd5898240;
    localparam logic [24:0] YAW_START    = 25'd17694720;
    localparam logic signed [23:0] PITCH_LIMIT = 24'sd5832704;
    localparam logic [13:0] ZOOM_MIN = 14'd256;
    localparam logic [13:0] ZOOM_MAX = 14'd11520;
    // 92 full turns, keeps the yaw sum non-negative before the modulo
    localparam logic [34:0] YAW_BIAS = 35'd2170552320;
    localparam logic [23:0] RECIP_360 = 24'd11930464;
    localparam logic [8:0] DEG_360 = 9'd360;
    localparam logic signed [15:0] VEC_ONE = 16'sd16384;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef enum logic [1:0] {OP_LOOK, OP_MOVE, OP_ZOOM, OP_START} t_op;

    typedef enum logic [2:0] {
        CFG_SENS, CFG_SPEED, CFG_START_X, CFG_START_Y, CFG_START_Z
    } t_cfg;

    typedef enum logic [2:0] {
        DIR_FWD, DIR_BACK, DIR_RIGHT, DIR_LEFT, DIR_UP, DIR_DOWN
    } t_dir;

    typedef enum logic [2:0] {TAG_SY, TAG_CY, TAG_SP, TAG_CP, TAG_YAW} t_tag;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_LOOK_DX, S_LOOK_DY, S_LOOK_PITCH, S_YAW_WAIT,
        S_VEC_ISSUE, S_VEC_WAIT, S_VEC_MUL, S_VEC_STORE,
        S_MOVE_VEL, S_MOVE_SAVE, S_MOVE_MUL, S_MOVE_POS, S_ZOOM, S_PUBLISH
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_CAPTURE, CMD_START, CMD_MUL_DX, CMD_MUL_DY, CMD_PITCH,
        CMD_ISSUE, CMD_VMUL, CMD_VSTORE, CMD_MUL_VEL, CMD_SAVE_VEL,
        CMD_MUL_STEP, CMD_POS, CMD_ZOOM, CMD_PUBLISH
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] idx;
    } t_ctl;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_sts;

    // taylor series sine of a Q30 radian angle, rounded to Q2.14
    function automatic logic signed [15:0] sine_entry(longint x_in);
        longint x;
        longint term;
        longint sum;
        longint r;
        x = x_in;
        if (x > PI_Q30) x = x - TWO_PI_Q30;
        if (x > HALF_PI_Q30) x = PI_Q30 - x;
        else if (x < -HALF_PI_Q30) x = -PI_Q30 - x;
        term = x;
        sum = x;
        for (int k = 0; k < 6; k++) begin
            term = term * x / Q30_ONE;
            term = term * x / Q30_ONE;
            // divide by (2k+2)(2k+3)
            case (k)
                0: term = -term / 64'sd6;
                1: term = -term / 64'sd20;
                2: term = -term / 64'sd42;
                3: term = -term / 64'sd72;
                4: term = -term / 64'sd110;
                default: term = -term / 64'sd156;
            endcase
            sum = sum + term;
        end
        if (sum >= 0) r = (sum + 32768) / 65536;
        else r = -((-sum + 32768) / 65536);
        return 16'(r);
    endfunction

endpackage

// File: hdl/efc_ctrl.sv
// sequencer for the fly camera update: walks each opcode through the datapath
// depends on efc_pkg
module efc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_opcode,
    output logic            o_in_ready,
    input  efc_pkg::t_sts   i_sts,
    output efc_pkg::t_ctl   o_ctl
);

    efc_pkg::t_state r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic r_report, n_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= efc_pkg::S_START;
            r_cnt <= 2'd0;
            r_report <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_report <= n_report;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_report = r_report;
        unique case (r_state)
            efc_pkg::S_IDLE: begin
                n_cnt = 2'd0;
                if (i_in_valid) begin
                    n_report = 1'b1;
                    unique case (efc_pkg::t_op'(i_opcode))
                        efc_pkg::OP_LOOK:  n_state = efc_pkg::S_LOOK_DX;
                        efc_pkg::OP_MOVE:  n_state = efc_pkg::S_MOVE_VEL;
                        efc_pkg::OP_ZOOM:  n_state = efc_pkg::S_ZOOM;
                        efc_pkg::OP_START: n_state = efc_pkg::S_START;
                    endcase
                end
            end
            efc_pkg::S_START:      n_state = efc_pkg::S_VEC_ISSUE;
            efc_pkg::S_LOOK_DX:    n_state = efc_pkg::S_LOOK_DY;
            efc_pkg::S_LOOK_DY:    n_state = efc_pkg::S_LOOK_PITCH;
            efc_pkg::S_LOOK_PITCH: n_state = efc_pkg::S_YAW_WAIT;
            efc_pkg::S_YAW_WAIT: begin
                if (!i_sts.pipe_busy) n_state = efc_pkg::S_VEC_ISSUE;
            end
            efc_pkg::S_VEC_ISSUE: begin
                if (r_cnt == 2'd3) begin
                    n_cnt = 2'd0;
                    n_state = efc_pkg::S_VEC_WAIT;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            efc_pkg::S_VEC_WAIT: begin
                if (!i_sts.pipe_busy) n_state = efc_pkg::S_VEC_MUL;
            end
            efc_pkg::S_VEC_MUL: n_state = efc_pkg::S_VEC_STORE;
            efc_pkg::S_VEC_STORE: begin
                if (r_cnt == 2'd3) begin
                    n_cnt = 2'd0;
                    n_state = r_report ? efc_pkg::S_PUBLISH : efc_pkg::S_IDLE;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                    n_state = efc_pkg::S_VEC_MUL;
                end
            end
            efc_pkg::S_MOVE_VEL:  n_state = efc_pkg::S_MOVE_SAVE;
            efc_pkg::S_MOVE_SAVE: n_state = efc_pkg::S_MOVE_MUL;
            efc_pkg::S_MOVE_MUL:  n_state = efc_pkg::S_MOVE_POS;
            efc_pkg::S_MOVE_POS: begin
                if (r_cnt == 2'd2) begin
                    n_cnt = 2'd0;
                    n_state = efc_pkg::S_PUBLISH;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                    n_state = efc_pkg::S_MOVE_MUL;
                end
            end
            efc_pkg::S_ZOOM: n_state = efc_pkg::S_PUBLISH;
            efc_pkg::S_PUBLISH: begin
                if (i_sts.out_free) n_state = efc_pkg::S_IDLE;
            end
            default: n_state = efc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_ctl.cmd = efc_pkg::CMD_NONE;
        o_ctl.idx = r_cnt;
        unique case (r_state)
            efc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_ctl.cmd = efc_pkg::CMD_CAPTURE;
            end
            efc_pkg::S_START:      o_ctl.cmd = efc_pkg::CMD_START;
            efc_pkg::S_LOOK_DX:    o_ctl.cmd = efc_pkg::CMD_MUL_DX;
            efc_pkg::S_LOOK_DY:    o_ctl.cmd = efc_pkg::CMD_MUL_DY;
            efc_pkg::S_LOOK_PITCH: o_ctl.cmd = efc_pkg::CMD_PITCH;
            efc_pkg::S_VEC_ISSUE:  o_ctl.cmd = efc_pkg::CMD_ISSUE;
            efc_pkg::S_VEC_MUL:    o_ctl.cmd = efc_pkg::CMD_VMUL;
            efc_pkg::S_VEC_STORE:  o_ctl.cmd = efc_pkg::CMD_VSTORE;
            efc_pkg::S_MOVE_VEL:   o_ctl.cmd = efc_pkg::CMD_MUL_VEL;
            efc_pkg::S_MOVE_SAVE:  o_ctl.cmd = efc_pkg::CMD_SAVE_VEL;
            efc_pkg::S_MOVE_MUL:   o_ctl.cmd = efc_pkg::CMD_MUL_STEP;
            efc_pkg::S_MOVE_POS:   o_ctl.cmd = efc_pkg::CMD_POS;
            efc_pkg::S_ZOOM:       o_ctl.cmd = efc_pkg::CMD_ZOOM;
            efc_pkg::S_PUBLISH: begin
                if (i_sts.out_free) o_ctl.cmd = efc_pkg::CMD_PUBLISH;
            end
            default: o_ctl.cmd = efc_pkg::CMD_NONE;
        endcase
    end

endmodule

// File: hdl/efc_dpath.sv
// datapath of the fly camera update: state, shared multiplier, angle to table index
// pipeline with sine rom, config registers and output word register; depends on efc_pkg
module efc_dpath #(
    parameter int SINE_TABLE_DEPTH = efc_pkg::SINE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  efc_pkg::t_ctl       i_ctl,
    output efc_pkg::t_sts       o_sts,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic signed [15:0]  i_look_dx,
    input  logic signed [15:0]  i_look_dy,
    input  logic [2:0]          i_move_dir,
    input  logic [15:0]         i_frame_time,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_pos_z,
    output logic signed [15:0]  o_front_x,
    output logic signed [15:0]  o_front_y,
    output logic signed [15:0]  o_front_z,
    output logic signed [15:0]  o_right_x,
    output logic signed [15:0]  o_right_z,
    output logic signed [15:0]  o_up_x,
    output logic signed [15:0]  o_up_y,
    output logic signed [15:0]  o_up_z,
    output logic [13:0]         o_zoom_deg
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int NMAX_A = 360 * SINE_TABLE_DEPTH + 181;
    localparam int NMAX = (NMAX_A > 66561) ? NMAX_A : 66561;
    localparam int NW = $clog2(NMAX);
    localparam int DW = $clog2(SINE_TABLE_DEPTH + 1) + 1;
    localparam int SW = 26 + DW;
    localparam int PW = NW + 24;
    localparam logic [NW-1:0] DEPTH_N = NW'(SINE_TABLE_DEPTH);

    // table angle step in Q30 radians, whole part and remainder over the depth
    localparam longint ROM_STEP_Q = efc_pkg::TWO_PI_Q30 / SINE_TABLE_DEPTH;
    localparam longint ROM_STEP_R = efc_pkg::TWO_PI_Q30 % SINE_TABLE_DEPTH;

    typedef logic signed [15:0] t_sine_rom [SINE_TABLE_DEPTH];

    function automatic t_sine_rom f_build_rom();
        t_sine_rom rom;
        longint x;
        longint r;
        x = 0;
        r = 0;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            rom[i] = efc_pkg::sine_entry(x);
            x = x + ROM_STEP_Q;
            r = r + ROM_STEP_R;
            if (r >= longint'(SINE_TABLE_DEPTH)) begin
                r = r - longint'(SINE_TABLE_DEPTH);
                x = x + 1;
            end
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_rom();

    // Q2.14 product rounded half away from zero
    function automatic logic signed [15:0] f_round14(logic signed [49:0] p);
        logic [49:0] m;
        logic [49:0] r;
        m = p[49] ? 50'(-p) : 50'(p);
        r = (m + 50'd8192) >> 14;
        return p[49] ? -$signed(r[15:0]) : $signed(r[15:0]);
    endfunction

    // move step taken to Q16.16, rounded half away from zero
    function automatic logic [31:0] f_step(logic signed [49:0] p);
        logic [49:0] m;
        logic [49:0] r;
        m = p[49] ? 50'(-p) : 50'(p);
        r = (m + 50'd2097152) >> 22;
        return p[49] ? -r[31:0] : r[31:0];
    endfunction

    function automatic logic [24:0] f_add_quarter(logic [24:0] a);
        logic [25:0] s;
        s = {1'b0, a} + {1'b0, efc_pkg::QUARTER_TURN};
        if (s >= {1'b0, efc_pkg::FULL_TURN}) s = s - {1'b0, efc_pkg::FULL_TURN};
        return s[24:0];
    endfunction

    // config and captured input
    logic [15:0] r_sens, r_speed;
    logic [31:0] r_start_x, r_start_y, r_start_z;
    logic signed [15:0] r_dx, r_dy;
    logic [2:0] r_dir;
    logic [15:0] r_ft;

    // camera state
    logic [31:0] r_pos_x, r_pos_y, r_pos_z;
    logic [24:0] r_yaw;
    logic signed [23:0] r_pitch;
    logic [13:0] r_zoom;
    logic signed [15:0] r_sy, r_cy, r_sp, r_cp;
    logic signed [15:0] r_vec [8];

    logic signed [49:0] r_prod;
    logic [32:0] r_ypos;
    logic [31:0] r_vel;

    // index pipeline
    logic r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld;
    efc_pkg::t_tag r_p1_tag, r_p2_tag, r_p3_tag, r_p4_tag;
    logic [NW-1:0] r_p1_n, r_p2_n, r_p3_q;
    logic [PW-1:0] r_p2_prod;
    logic signed [15:0] r_p4_sin;

    logic r_out_valid;

    // multiplier operands
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] mul_p;
    logic signed [15:0] comp;

    always_comb begin
        comp = '0;
        unique case (r_dir)
            efc_pkg::DIR_FWD, efc_pkg::DIR_BACK: begin
                if (i_ctl.idx == 2'd0) comp = r_vec[0];
                else if (i_ctl.idx == 2'd1) comp = r_vec[1];
                else comp = r_vec[2];
            end
            efc_pkg::DIR_RIGHT, efc_pkg::DIR_LEFT: begin
                if (i_ctl.idx == 2'd0) comp = r_vec[3];
                else if (i_ctl.idx == 2'd2) comp = r_vec[4];
            end
            efc_pkg::DIR_UP, efc_pkg::DIR_DOWN: begin
                if (i_ctl.idx == 2'd1) comp = efc_pkg::VEC_ONE;
            end
            default: comp = '0;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_ctl.cmd)
            efc_pkg::CMD_MUL_DX: begin
                mul_a = 33'(r_dx);
                mul_b = $signed({1'b0, r_sens});
            end
            efc_pkg::CMD_MUL_DY: begin
                mul_a = 33'(r_dy);
                mul_b = $signed({1'b0, r_sens});
            end
            efc_pkg::CMD_MUL_VEL: begin
                mul_a = $signed({17'd0, r_ft});
                mul_b = $signed({1'b0, r_speed});
            end
            efc_pkg::CMD_MUL_STEP: begin
                mul_a = $signed({1'b0, r_vel});
                mul_b = 17'(comp);
            end
            efc_pkg::CMD_VMUL: begin
                unique case (i_ctl.idx)
                    2'd0: begin mul_a = 33'(r_cy); mul_b = 17'(r_cp); end
                    2'd1: begin mul_a = 33'(r_sy); mul_b = 17'(r_cp); end
                    2'd2: begin mul_a = 33'(r_cy); mul_b = 17'(r_sp); end
                    2'd3: begin mul_a = 33'(r_sy); mul_b = 17'(r_sp); end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // look sums
    logic signed [35:0] ysum, psum;
    localparam logic signed [35:0] P_HI = 36'(efc_pkg::PITCH_LIMIT);
    localparam logic signed [35:0] P_LO = -P_HI;

    assign ysum = $signed({11'd0, r_yaw}) + 36'(r_prod) + $signed({1'b0, efc_pkg::YAW_BIAS});
    assign psum = 36'(r_pitch) + 36'(r_prod);

    // zoom
    logic signed [25:0] zsum;
    assign zsum = $signed({12'd0, r_zoom}) - (26'(r_dy) <<< 8);

    // stage 1: angle to scaled index numerator, or whole degrees of the yaw sum for the yaw wrap
    logic [24:0] pitch_pos, ang;
    logic [SW-1:0] scaled;
    logic [NW-1:0] p1_n;
    efc_pkg::t_tag p1_tag;

    always_comb begin
        pitch_pos = r_pitch[23] ? 25'(r_pitch) + efc_pkg::FULL_TURN : 25'(r_pitch);
        unique case (i_ctl.idx)
            2'd0: begin ang = r_yaw; p1_tag = efc_pkg::TAG_SY; end
            2'd1: begin ang = f_add_quarter(r_yaw); p1_tag = efc_pkg::TAG_CY; end
            2'd2: begin ang = pitch_pos; p1_tag = efc_pkg::TAG_SP; end
            2'd3: begin ang = f_add_quarter(pitch_pos); p1_tag = efc_pkg::TAG_CP; end
        endcase
        scaled = SW'(ang) * SW'(SINE_TABLE_DEPTH) + SW'(efc_pkg::HALF_TURN);
        p1_n = scaled[16 +: NW];
        if (i_ctl.cmd == efc_pkg::CMD_PITCH) begin
            p1_tag = efc_pkg::TAG_YAW;
            p1_n = NW'(r_ypos[32:16]);
        end
    end

    // stage 3: quotient by 360 with one correction step
    logic [NW-1:0] q0, q;
    logic [NW:0] rem;

    always_comb begin
        q0 = NW'(r_p2_prod >> 32);
        rem = (NW+1)'(r_p2_n) - (NW+1)'(q0) * (NW+1)'(efc_pkg::DEG_360);
        q = (rem >= (NW+1)'(efc_pkg::DEG_360)) ? q0 + NW'(1) : q0;
    end

    logic [AW-1:0] rom_addr;
    assign rom_addr = (r_p3_q == DEPTH_N) ? '0 : AW'(r_p3_q);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens <= 16'd6554;
            r_speed <= 16'd640;
            r_start_x <= '0;
            r_start_y <= '0;
            r_start_z <= '0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (efc_pkg::t_cfg'(i_cfg_index))
                    efc_pkg::CFG_SENS:    r_sens <= i_cfg_data[15:0];
                    efc_pkg::CFG_SPEED:   r_speed <= i_cfg_data[15:0];
                    efc_pkg::CFG_START_X: r_start_x <= i_cfg_data;
                    efc_pkg::CFG_START_Y: r_start_y <= i_cfg_data;
                    efc_pkg::CFG_START_Z: r_start_z <= i_cfg_data;
                    default: ;
                endcase
            end
            r_p1_vld <= (i_ctl.cmd == efc_pkg::CMD_ISSUE) || (i_ctl.cmd == efc_pkg::CMD_PITCH);
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld && (r_p3_tag != efc_pkg::TAG_YAW);
            if (i_ctl.cmd == efc_pkg::CMD_PUBLISH) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_p1_n <= p1_n;
        r_p1_tag <= p1_tag;
        r_p2_n <= r_p1_n;
        r_p2_tag <= r_p1_tag;
        r_p2_prod <= PW'(r_p1_n) * PW'(efc_pkg::RECIP_360);
        r_p3_q <= q;
        r_p3_tag <= r_p2_tag;
        r_p4_tag <= r_p3_tag;
        r_p4_sin <= SINE_ROM[rom_addr];

        if (r_p3_vld && r_p3_tag == efc_pkg::TAG_YAW) begin
            r_yaw <= 25'(r_ypos - 33'(r_p3_q) * 33'(efc_pkg::FULL_TURN));
        end

        if (r_p4_vld) begin
            unique case (r_p4_tag)
                efc_pkg::TAG_SY: r_sy <= r_p4_sin;
                efc_pkg::TAG_CY: r_cy <= r_p4_sin;
                efc_pkg::TAG_SP: r_sp <= r_p4_sin;
                efc_pkg::TAG_CP: r_cp <= r_p4_sin;
                default: ;
            endcase
        end

        unique case (i_ctl.cmd)
            efc_pkg::CMD_CAPTURE: begin
                r_dx <= i_look_dx;
                r_dy <= i_look_dy;
                r_dir <= i_move_dir;
                r_ft <= i_frame_time;
            end
            efc_pkg::CMD_START: begin
                r_pos_x <= r_start_x;
                r_pos_y <= r_start_y;
                r_pos_z <= r_start_z;
                r_yaw <= efc_pkg::YAW_START;
                r_pitch <= '0;
                r_zoom <= efc_pkg::ZOOM_MAX;
            end
            efc_pkg::CMD_MUL_DX, efc_pkg::CMD_MUL_VEL, efc_pkg::CMD_MUL_STEP,
            efc_pkg::CMD_VMUL: begin
                r_prod <= mul_p;
            end
            efc_pkg::CMD_MUL_DY: begin
                r_prod <= mul_p;
                r_ypos <= ysum[32:0];
            end
            efc_pkg::CMD_PITCH: begin
                if (psum > P_HI) r_pitch <= efc_pkg::PITCH_LIMIT;
                else if (psum < P_LO) r_pitch <= -efc_pkg::PITCH_LIMIT;
                else r_pitch <= psum[23:0];
            end
            efc_pkg::CMD_VSTORE: begin
                r_vec[1] <= r_sp;
                r_vec[3] <= -r_sy;
                r_vec[4] <= r_cy;
                r_vec[6] <= r_cp;
                unique case (i_ctl.idx)
                    2'd0: r_vec[0] <= f_round14(r_prod);
                    2'd1: r_vec[2] <= f_round14(r_prod);
                    2'd2: r_vec[5] <= -f_round14(r_prod);
                    2'd3: r_vec[7] <= -f_round14(r_prod);
                endcase
            end
            efc_pkg::CMD_SAVE_VEL: r_vel <= r_prod[31:0];
            efc_pkg::CMD_POS: begin
                unique case (i_ctl.idx)
                    2'd0: r_pos_x <= r_dir[0] ? r_pos_x - f_step(r_prod)
                                              : r_pos_x + f_step(r_prod);
                    2'd1: r_pos_y <= r_dir[0] ? r_pos_y - f_step(r_prod)
                                              : r_pos_y + f_step(r_prod);
                    default: r_pos_z <= r_dir[0] ? r_pos_z - f_step(r_prod)
                                                 : r_pos_z + f_step(r_prod);
                endcase
            end
            efc_pkg::CMD_ZOOM: begin
                if (zsum < $signed({12'd0, efc_pkg::ZOOM_MIN})) r_zoom <= efc_pkg::ZOOM_MIN;
                else if (zsum > $signed({12'd0, efc_pkg::ZOOM_MAX})) r_zoom <= efc_pkg::ZOOM_MAX;
                else r_zoom <= zsum[13:0];
            end
            efc_pkg::CMD_PUBLISH: begin
                o_pos_x <= r_pos_x;
                o_pos_y <= r_pos_y;
                o_pos_z <= r_pos_z;
                o_front_x <= r_vec[0];
                o_front_y <= r_vec[1];
                o_front_z <= r_vec[2];
                o_right_x <= r_vec[3];
                o_right_z <= r_vec[4];
                o_up_x <= r_vec[5];
                o_up_y <= r_vec[6];
                o_up_z <= r_vec[7];
                o_zoom_deg <= r_zoom;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_sts.pipe_busy = r_p1_vld | r_p2_vld | r_p3_vld | r_p4_vld;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

// File: hdl/euler_fly_camera_update.sv
// Free-look fly camera update, top level.
// Input channel (i_in_valid/o_in_ready) takes one word per event: opcode look, move,
// zoom or reset to start, with mouse deltas, move direction and frame time.
// Output channel (o_out_valid/i_out_ready) gives one word per input word: position,
// front, right and up vectors and field of view after the operation.
// Config channel (i_cfg_valid/o_cfg_ready) writes sensitivity, speed and start
// position; it is always ready and should only be used while the block is idle.
// Vector updates run four angles through a shared index pipeline (multiply, divide
// by 360 via reciprocal, sine rom read) and four products through one shared
// multiplier; one word is in flight at a time.
// A new input word is taken while the previous result still waits at the output; the
// block stalls only before loading a new result into the output register.
// After reset the block loads the start pose and computes the view vectors
// with o_in_ready low, then goes idle.
// depends on efc_pkg, efc_ctrl, efc_dpath
module euler_fly_camera_update #(
    parameter int SINE_TABLE_DEPTH = efc_pkg::SINE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_opcode,
    input  logic signed [15:0]  i_look_dx,
    input  logic signed [15:0]  i_look_dy,
    input  logic [2:0]          i_move_dir,
    input  logic [15:0]         i_frame_time,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_pos_z,
    output logic signed [15:0]  o_front_x,
    output logic signed [15:0]  o_front_y,
    output logic signed [15:0]  o_front_z,
    output logic signed [15:0]  o_right_x,
    output logic signed [15:0]  o_right_z,
    output logic signed [15:0]  o_up_x,
    output logic signed [15:0]  o_up_y,
    output logic signed [15:0]  o_up_z,
    output logic [13:0]         o_zoom_deg,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    efc_pkg::t_ctl ctl;
    efc_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    efc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    efc_dpath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_look_dx    (i_look_dx),
        .i_look_dy    (i_look_dy),
        .i_move_dir   (i_move_dir),
        .i_frame_time (i_frame_time),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_pos_z      (o_pos_z),
        .o_front_x    (o_front_x),
        .o_front_y    (o_front_y),
        .o_front_z    (o_front_z),
        .o_right_x    (o_right_x),
        .o_right_z    (o_right_z),
        .o_up_x       (o_up_x),
        .o_up_y       (o_up_y),
        .o_up_z       (o_up_z),
        .o_zoom_deg   (o_zoom_deg)
    );

`ifndef SYNTHESIS
    // one word at a time: an accepted word closes the input until its result is out
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready after accept");

    // index pipeline must be drained whenever a new word can come in
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !sts.pipe_busy)
        else $error("index pipeline busy while idle");

    // a publish always leaves a valid result
    a_publish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.cmd == efc_pkg::CMD_PUBLISH) |=> o_out_valid)
        else $error("publish without output valid");

    // publishing never overwrites a result that was not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.cmd == efc_pkg::CMD_PUBLISH) |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten");
`endif

endmodule

// File: bench/tb.sv
// testbench for euler_fly_camera_update: directed and random camera events, results
// checked against an in-bench fixed-point camera predictor
// depends on efc_pkg and the euler_fly_camera_update rtl
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = 1024;
    localparam longint FULL = 64'sd23592960;
    localparam longint QUART = 64'sd5898240;
    localparam longint PLIM = 64'sd5832704;

    typedef struct packed {
        logic [31:0] px, py, pz;
        logic [15:0] fx, fy, fz, rx, rz, ux, uy, uz;
        logic [13:0] zm;
    } t_pose;

    logic i_clk = 0, i_rst_n = 0;
    logic i_in_valid = 0, i_out_ready = 0, i_cfg_valid = 0;
    logic [1:0] i_opcode = 0;
    logic signed [15:0] i_look_dx = 0, i_look_dy = 0;
    logic [2:0] i_move_dir = 0, i_cfg_index = 0;
    logic [15:0] i_frame_time = 0;
    logic [31:0] i_cfg_data = 0;
    logic o_in_ready, o_out_valid, o_cfg_ready;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [15:0] o_front_x, o_front_y, o_front_z, o_right_x, o_right_z;
    logic signed [15:0] o_up_x, o_up_y, o_up_z;
    logic [13:0] o_zoom_deg;

    euler_fly_camera_update DUT (.*);

    initial forever #5 i_clk = ~i_clk;

    // predictor state
    logic signed [15:0] sin_rom [DEPTH];
    logic [15:0] m_sens, m_speed;
    logic [31:0] m_start [3];
    logic [31:0] m_pos [3];
    longint m_yaw, m_pitch;
    int m_zoom;
    int m_vec [8];

    t_pose pose_q [$];
    int errors = 0;
    int n_sent = 0, n_checked = 0;
    bit idle_on = 1;

    function automatic int rd_table(longint a);
        longint idx;
        idx = (a * DEPTH + 64'sd11796480) / FULL;
        return sin_rom[idx % DEPTH];
    endfunction

    function automatic int qmul(int a, int b);
        int p;
        p = a * b;
        if (p >= 0) return (p + 8192) >>> 14;
        return -((-p + 8192) >>> 14);
    endfunction

    task automatic refresh_vectors();
        longint pa;
        int sy, cy, sp, cp;
        pa = m_pitch < 0 ? m_pitch + FULL : m_pitch;
        sy = rd_table(m_yaw % FULL);
        cy = rd_table((m_yaw + QUART) % FULL);
        sp = rd_table(pa % FULL);
        cp = rd_table((pa + QUART) % FULL);
        m_vec = '{qmul(cy, cp), sp, qmul(sy, cp), -sy, cy, -qmul(cy, sp), cp,
                  -qmul(sy, sp)};
    endtask

    task automatic load_start_pose();
        m_pos = m_start;
        m_yaw = 64'sd17694720;
        m_pitch = 0;
        m_zoom = 11520;
        refresh_vectors();
    endtask

    function automatic logic [31:0] move_part(longint vel, int comp);
        longint d;
        d = vel * comp;
        if (d >= 0) d = (d + 2097152) / 4194304;
        else d = -((-d + 2097152) / 4194304);
        return d[31:0];
    endfunction

    task automatic predict_pose(efc_pkg::t_op op, logic signed [15:0] dx,
                                logic signed [15:0] dy, logic [2:0] dir, logic [15:0] ft);
        longint y, p, vel;
        int v [3];
        int z;
        logic [31:0] d;
        t_pose e;
        case (op)
            efc_pkg::OP_LOOK: begin
                y = (m_yaw + longint'(dx) * longint'(m_sens)) % FULL;
                if (y < 0) y += FULL;
                p = m_pitch + longint'(dy) * longint'(m_sens);
                if (p > PLIM) p = PLIM;
                else if (p < -PLIM) p = -PLIM;
                m_yaw = y;
                m_pitch = p;
                refresh_vectors();
            end
            efc_pkg::OP_MOVE: begin
                vel = longint'(ft) * longint'(m_speed);
                v = '{0, 0, 0};
                if (dir <= efc_pkg::DIR_BACK) v = '{m_vec[0], m_vec[1], m_vec[2]};
                else if (dir <= efc_pkg::DIR_LEFT) v = '{m_vec[3], 0, m_vec[4]};
                else if (dir <= efc_pkg::DIR_DOWN) v = '{0, 16384, 0};
                for (int i = 0; i < 3; i++) begin
                    d = move_part(vel, v[i]);
                    m_pos[i] = dir[0] ? m_pos[i] - d : m_pos[i] + d;
                end
            end
            efc_pkg::OP_ZOOM: begin
                z = m_zoom - int'(dy) * 256;
                m_zoom = z < 256 ? 256 : (z > 11520 ? 11520 : z);
            end
            default: load_start_pose();
        endcase
        e.px = m_pos[0]; e.py = m_pos[1]; e.pz = m_pos[2];
        e.fx = 16'(m_vec[0]); e.fy = 16'(m_vec[1]); e.fz = 16'(m_vec[2]);
        e.rx = 16'(m_vec[3]); e.rz = 16'(m_vec[4]);
        e.ux = 16'(m_vec[5]); e.uy = 16'(m_vec[6]); e.uz = 16'(m_vec[7]);
        e.zm = m_zoom[13:0];
        pose_q.push_back(e);
    endtask

    task automatic random_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
    endtask

    task automatic send_event(efc_pkg::t_op op, logic signed [15:0] dx,
                              logic signed [15:0] dy, logic [2:0] dir, logic [15:0] ft);
        random_gap();
        i_in_valid <= 1;
        i_opcode <= op; i_look_dx <= dx; i_look_dy <= dy;
        i_move_dir <= dir; i_frame_time <= ft;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_pose(op, dx, dy, dir, ft);
        n_sent++;
        @(negedge i_clk);
        i_in_valid <= 0;
        // the block is busy for this cycle anyway
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (pose_q.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(efc_pkg::t_cfg idx, logic [31:0] val);
        drain();
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            efc_pkg::CFG_SENS: m_sens = val[15:0];
            efc_pkg::CFG_SPEED: m_speed = val[15:0];
            efc_pkg::CFG_START_X: m_start[0] = val;
            efc_pkg::CFG_START_Y: m_start[1] = val;
            default: m_start[2] = val;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic random_event(int style);
        logic [15:0] a, b, f;
        int r;
        a = 16'($urandom); b = 16'($urandom); f = 16'($urandom);
        if (style == 0 && $urandom_range(0, 1)) begin
            a = $signed(a) >>> $urandom_range(0, 14);
            b = $signed(b) >>> $urandom_range(0, 14);
        end
        r = $urandom_range(0, 19);
        if (r < 8) send_event(efc_pkg::OP_LOOK, a, b, 3'($urandom), f);
        else if (r < 15) send_event(efc_pkg::OP_MOVE, a, b, 3'($urandom_range(0, 7)), f);
        else if (r < 18) send_event(efc_pkg::OP_ZOOM, a, $signed(b) >>> $urandom_range(0, 15),
                                    3'($urandom), f);
        else send_event(efc_pkg::OP_START, a, b, 3'($urandom), f);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_pose e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pose_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = pose_q.pop_front();
                n_checked++;
                if (o_pos_x !== e.px) begin
                    $error("pos_x exp %0h got %0h", e.px, o_pos_x); errors++;
                end
                if (o_pos_y !== e.py) begin
                    $error("pos_y exp %0h got %0h", e.py, o_pos_y); errors++;
                end
                if (o_pos_z !== e.pz) begin
                    $error("pos_z exp %0h got %0h", e.pz, o_pos_z); errors++;
                end
                if (o_front_x !== e.fx) begin
                    $error("front_x exp %0h got %0h", e.fx, o_front_x); errors++;
                end
                if (o_front_y !== e.fy) begin
                    $error("front_y exp %0h got %0h", e.fy, o_front_y); errors++;
                end
                if (o_front_z !== e.fz) begin
                    $error("front_z exp %0h got %0h", e.fz, o_front_z); errors++;
                end
                if (o_right_x !== e.rx) begin
                    $error("right_x exp %0h got %0h", e.rx, o_right_x); errors++;
                end
                if (o_right_z !== e.rz) begin
                    $error("right_z exp %0h got %0h", e.rz, o_right_z); errors++;
                end
                if (o_up_x !== e.ux) begin
                    $error("up_x exp %0h got %0h", e.ux, o_up_x); errors++;
                end
                if (o_up_y !== e.uy) begin
                    $error("up_y exp %0h got %0h", e.uy, o_up_y); errors++;
                end
                if (o_up_z !== e.uz) begin
                    $error("up_z exp %0h got %0h", e.uz, o_up_z); errors++;
                end
                if (o_zoom_deg !== e.zm) begin
                    $error("zoom_deg exp %0h got %0h", e.zm, o_zoom_deg); errors++;
                end
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            i_out_ready <= 1;
        end
    end

    task automatic test_directed_look();
        send_event(efc_pkg::OP_LOOK, 16'sd0, 16'sd0, 0, 0);
        send_event(efc_pkg::OP_LOOK, 16'sh7fff, 16'sh7fff, 0, 0);
        send_event(efc_pkg::OP_LOOK, -16'sd32768, -16'sd32768, 7, 16'hffff);
        send_event(efc_pkg::OP_LOOK, 16'sd100, 16'sd0, 0, 0);
        send_event(efc_pkg::OP_LOOK, -16'sd100, 16'sd900, 0, 0);
    endtask

    task automatic test_directed_move();
        for (int d = 0; d < 8; d++)
            send_event(efc_pkg::OP_MOVE, 16'sh7fff, -16'sd1, 3'(d), 16'hffff);
        send_event(efc_pkg::OP_MOVE, 0, 0, efc_pkg::DIR_FWD, 0);
        send_event(efc_pkg::OP_MOVE, 0, 0, efc_pkg::DIR_BACK, 16'd1);
    endtask

    task automatic test_directed_zoom();
        send_event(efc_pkg::OP_ZOOM, 16'sh7fff, 16'sd1, 0, 0);
        send_event(efc_pkg::OP_ZOOM, 0, 16'sd50, 0, 0);
        send_event(efc_pkg::OP_ZOOM, 0, -16'sd3, 0, 0);
        send_event(efc_pkg::OP_ZOOM, 0, -16'sd32768, 0, 0);
        send_event(efc_pkg::OP_ZOOM, 0, 16'sh7fff, 0, 0);
        send_event(efc_pkg::OP_START, 16'sh7fff, 16'sh7fff, 7, 16'hffff);
    endtask

    task automatic test_config_sweep();
        write_reg(efc_pkg::CFG_SENS, 32'hffff);
        write_reg(efc_pkg::CFG_SPEED, 32'hffff);
        write_reg(efc_pkg::CFG_START_X, 32'h7fffffff);
        write_reg(efc_pkg::CFG_START_Y, 32'h80000000);
        write_reg(efc_pkg::CFG_START_Z, 32'h12345678);
        send_event(efc_pkg::OP_START, 0, 0, 0, 0);
        for (int i = 0; i < 10; i++) random_event(0);
        write_reg(efc_pkg::CFG_SENS, 32'h0);
        write_reg(efc_pkg::CFG_SPEED, 32'h0);
        for (int i = 0; i < 6; i++) random_event(0);
    endtask

    task automatic test_random(int count);
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(efc_pkg::CFG_SENS, $urandom);
            write_reg(efc_pkg::CFG_SPEED, $urandom);
            write_reg(efc_pkg::CFG_START_X, $urandom);
            write_reg(efc_pkg::CFG_START_Y, $urandom);
            write_reg(efc_pkg::CFG_START_Z, $urandom);
            if (ph == 3) idle_on = 0;
            for (int i = 0; i < count / 4; i++) begin
                random_event(ph & 1);
                // once per phase the sender holds off until the block has drained
                if (i == 50) while (pose_q.size() != 0) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++)
            sin_rom[i] = efc_pkg::sine_entry((efc_pkg::TWO_PI_Q30 * i) / DEPTH);
        m_sens = 16'd6554; m_speed = 16'd640;
        m_start = '{0, 0, 0};
        load_start_pose();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        test_directed_look();
        test_directed_move();
        test_directed_zoom();
        test_config_sweep();
        test_random(1000);
        drain();
        $display("sent %0d camera events, checked %0d result words", n_sent, n_checked);
        $display("covered look, move in all directions, zoom, start reload, config sweeps");
        if (errors == 0 && pose_q.size() == 0) $display("** euler_fly_camera_update: PASSED **");
        else $display("** euler_fly_camera_update: FAILED **");
        $finish;
    end

    initial begin
        #5ms;
        $display("** euler_fly_camera_update: FAILED **");
        $finish;
    end
endmodule

// File: files.f
hdl/efc_pkg.sv
hdl/efc_ctrl.sv
hdl/efc_dpath.sv
hdl/euler_fly_camera_update.sv
bench/tb.sv
